@@ sv/abc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abc_pkg
// Shared types and constants for the adaptive batch coalescer: request and
// response payloads, the decoded command, configuration and register codes.
// ----------------------------------------------------------------------------
package abc_pkg;

   localparam int          QUEUE_DEPTH   = 2;
   localparam int          CSR_ADDR_W    = 4;
   localparam int          CSR_DATA_W    = 32;

   localparam logic [7:0]  MIN_BATCH_RST = 8'd50;
   localparam logic [7:0]  MAX_BATCH_RST = 8'd160;
   localparam logic        ADAPT_EN_RST  = 1'b1;

   localparam logic        REQ_DRAIN     = 1'b1;

   typedef enum logic [1:0] {
      REG_MIN_BATCH    = 2'd0,
      REG_MAX_BATCH    = 2'd1,
      REG_ADAPT_ENABLE = 2'd2
   } csr_reg_type;

   typedef enum logic {
      OP_ARRIVAL = 1'b0,
      OP_DRAIN   = 1'b1
   } cmd_op_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] now_seconds;
      logic        send_fail;
   } req_payload_type;

   typedef struct packed {
      logic        flush;
      logic [15:0] batch_count;
      logic        error_status;
      logic [7:0]  current_threshold;
   } rsp_payload_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [31:0] now_seconds;
      logic        send_fail;
   } cmd_type;

   typedef struct packed {
      logic [7:0] min_batch;
      logic [7:0] max_batch;
      logic       adapt_enable;
   } cfg_type;

endpackage
`default_nettype wire

@@ sv/abc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abc_front
// Accepts requests, decodes each into an arrival or drain command and holds
// it in a short queue until the back end takes it.
// ----------------------------------------------------------------------------
module abc_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  abc_pkg::req_payload_type req_payload,
   output logic                     cmd_valid,
   input  wire                      cmd_ready,
   output abc_pkg::cmd_type         cmd
);
   import abc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   cmd_type          cmd_in;
   logic             push;
   logic             pop;

   always_comb begin
      cmd_in.op          = (req_payload.req_type == REQ_DRAIN) ? OP_DRAIN : OP_ARRIVAL;
      cmd_in.now_seconds = req_payload.now_seconds;
      cmd_in.send_fail   = req_payload.send_fail;
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/abc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abc_back
// Executes one command per cycle unless its response stalls: counts pending packets,
// decides on flush or send error, adapts the threshold per window and registers the response.
// ----------------------------------------------------------------------------
module abc_back #(
   parameter int WINDOW_SECONDS = 5
) (
   input  wire                      clock,
   input  wire                      reset,
   input  abc_pkg::cfg_type         cfg,
   input  wire                      cmd_valid,
   output logic                     cmd_ready,
   input  abc_pkg::cmd_type         cmd,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output abc_pkg::rsp_payload_type rsp_payload
);
   import abc_pkg::*;

   localparam int WIN_W  = $clog2(WINDOW_SECONDS + 1);
   localparam int PROD_W = 9 + WIN_W;

   logic [15:0]       pending_ff,  pending_in;
   logic [7:0]        thresh_ff,   thresh_in;
   logic [31:0]       win_start_ff, win_start_in;
   logic [31:0]       arrivals_ff, arrivals_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic              fire;
   logic              drain;
   logic [7:0]        thr_eff;
   logic [15:0]       pend_inc;
   logic [31:0]       arr_inc;
   logic              due;
   logic              send_err;
   logic              do_flush;
   logic [31:0]       win_end;
   logic              roll;
   logic [PROD_W-1:0] hi_bound;
   logic [PROD_W-1:0] lo_bound;
   logic              rate_hi;
   logic              rate_lo;
   logic [8:0]        dbl;
   logic [7:0]        half;
   logic [7:0]        thr_up;
   logic [7:0]        thr_dn;

   assign cmd_ready   = !rsp_valid_ff || rsp_ready;
   assign fire        = cmd_valid && cmd_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      drain    = (cmd.op == OP_DRAIN);
      thr_eff  = drain ? 8'd0 : thresh_ff;
      pend_inc = (!drain && pending_ff != 16'hFFFF) ? pending_ff + 16'd1 : pending_ff;
      arr_inc  = (!drain && arrivals_ff != 32'hFFFF_FFFF) ? arrivals_ff + 32'd1 : arrivals_ff;
      due      = pend_inc > {8'd0, thr_eff};
      send_err = due && cmd.send_fail;
      do_flush = due && !cmd.send_fail;
      win_end  = win_start_ff + 32'(WINDOW_SECONDS);
      roll     = !send_err && cfg.adapt_enable && (win_end < cmd.now_seconds);

      // rate > 2t  <=>  arrivals >= W*(2t+1);  rate < t/2  <=>  arrivals < W*(t/2)
      hi_bound = PROD_W'(WINDOW_SECONDS) * PROD_W'({thr_eff, 1'b1});
      lo_bound = PROD_W'(WINDOW_SECONDS) * PROD_W'(thr_eff[7:1]);
      rate_hi  = arr_inc >= 32'(hi_bound);
      rate_lo  = arr_inc <  32'(lo_bound);

      dbl      = {thr_eff, 1'b0};
      half     = {1'b0, thr_eff[7:1]};
      thr_up   = (dbl > {1'b0, cfg.max_batch}) ? cfg.max_batch : dbl[7:0];
      thr_dn   = (half < cfg.min_batch) ? cfg.min_batch : half;

      thresh_in    = thr_eff;
      win_start_in = win_start_ff;
      arrivals_in  = arr_inc;
      if (roll) begin
         if (rate_hi) begin
            thresh_in = thr_up;
         end else if (rate_lo) begin
            thresh_in = thr_dn;
         end
         win_start_in = cmd.now_seconds;
         arrivals_in  = 32'd0;
      end
      pending_in = do_flush ? 16'd0 : pend_inc;

      rsp_in.flush             = do_flush;
      rsp_in.batch_count       = pend_inc;
      rsp_in.error_status      = send_err;
      rsp_in.current_threshold = thresh_in;

      rsp_valid_in = cmd_ready ? cmd_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         thresh_ff    <= MIN_BATCH_RST;
         win_start_ff <= '0;
         arrivals_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            pending_ff   <= pending_in;
            thresh_ff    <= thresh_in;
            win_start_ff <= win_start_in;
            arrivals_ff  <= arrivals_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/adaptive_batch_coalescer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_batch_coalescer_core
// Adaptive packet batching: counts arrivals, flushes above an adaptive
// threshold, drains on request and rescales the threshold per time window.
//
//   Channel   Direction  Handshake               Carries
//   req_*     in         valid/ready             arrival or drain, time, fail
//   rsp_*     out        valid/ready             flush, count, error, threshold
//   csr_*     in/out     APB-style, pready = 1   min_batch, max_batch, enable
//
// One request per cycle sustained while responses are taken; a response passes
// through the front queue and then the output register after its request is taken.
// The rate is set by the back end, which updates its state for each command it takes.
// Reset is synchronous and clears the queue, the counters and the response.
// A stalled response holds the back end; the front queue keeps taking
// requests until its two entries are full.
// ----------------------------------------------------------------------------
module adaptive_batch_coalescer_core #(
   parameter int WINDOW_SECONDS = 5
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  abc_pkg::req_payload_type              req_payload,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output abc_pkg::rsp_payload_type              rsp_payload,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [abc_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  wire  [abc_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [abc_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);
   import abc_pkg::*;

   logic [7:0]  min_batch_ff, min_batch_in;
   logic [7:0]  max_batch_ff, max_batch_in;
   logic        adapt_en_ff,  adapt_en_in;
   logic        csr_wr;
   csr_reg_type csr_sel;
   cfg_type     cfg;
   logic        cmd_valid;
   logic        cmd_ready;
   cmd_type     cmd;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_reg_type'(csr_paddr[3:2]);

   always_comb begin
      min_batch_in = min_batch_ff;
      max_batch_in = max_batch_ff;
      adapt_en_in  = adapt_en_ff;
      csr_prdata   = '0;
      unique case (csr_sel)
         REG_MIN_BATCH: begin
            csr_prdata = CSR_DATA_W'(min_batch_ff);
            if (csr_wr) min_batch_in = csr_pwdata[7:0];
         end
         REG_MAX_BATCH: begin
            csr_prdata = CSR_DATA_W'(max_batch_ff);
            if (csr_wr) max_batch_in = csr_pwdata[7:0];
         end
         REG_ADAPT_ENABLE: begin
            csr_prdata = CSR_DATA_W'(adapt_en_ff);
            if (csr_wr) adapt_en_in = csr_pwdata[0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_batch_ff <= MIN_BATCH_RST;
         max_batch_ff <= MAX_BATCH_RST;
         adapt_en_ff  <= ADAPT_EN_RST;
      end else begin
         min_batch_ff <= min_batch_in;
         max_batch_ff <= max_batch_in;
         adapt_en_ff  <= adapt_en_in;
      end
   end

   always_comb begin
      cfg.min_batch    = min_batch_ff;
      cfg.max_batch    = max_batch_ff;
      cfg.adapt_enable = adapt_en_ff;
   end

   abc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd)
   );

   abc_back #(
      .WINDOW_SECONDS (WINDOW_SECONDS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_flush_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.flush |->
         !rsp_payload.error_status && (rsp_payload.batch_count != 16'd0))
      else $error("flush with error or empty batch");

   a_error_above_thresh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error_status |->
         rsp_payload.batch_count > {8'd0, rsp_payload.current_threshold})
      else $error("send error without count above threshold");

   a_full_after_push: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(req_valid && req_ready) || $past(!req_ready))
      else $error("request queue filled without a push");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the adaptive batch coalescer. A tracker class
// predicts the flush, pending count, send error and threshold of every
// request and holds the responses due; each response is checked field by
// field. The run covers time extremes and wrap, a failed-send burst that
// holds the pending count, several register settings, drains, random gaps
// on both sides and a long response stall.
// ----------------------------------------------------------------------------
import abc_pkg::*;

class coalescer_tracker;
   localparam int WINDOW_SECONDS = 5;

   logic [15:0]     pending;
   logic [7:0]      thresh;
   logic [31:0]     win_start;
   logic [31:0]     win_arrivals;
   logic [7:0]      min_batch;
   logic [7:0]      max_batch;
   bit              adapt_on;
   int              rsp_seen;
   rsp_payload_type due_responses[$];

   function new();
      min_batch    = MIN_BATCH_RST;
      max_batch    = MAX_BATCH_RST;
      adapt_on     = ADAPT_EN_RST;
      pending      = '0;
      thresh       = MIN_BATCH_RST;
      win_start    = '0;
      win_arrivals = '0;
      rsp_seen     = 0;
   endfunction

   function void set_config(csr_reg_type r, logic [7:0] v);
      case (r)
         REG_MIN_BATCH:    min_batch = v;
         REG_MAX_BATCH:    max_batch = v;
         REG_ADAPT_ENABLE: adapt_on  = v[0];
         default: ;
      endcase
   endfunction

   function int outstanding();
      return due_responses.size();
   endfunction

   function void note_request(req_payload_type r);
      rsp_payload_type e;
      logic [31:0]     win_end;
      int unsigned     rate;
      int unsigned     dbl;
      int unsigned     half;
      e = '0;
      if (cmd_op_type'(r.req_type) == OP_DRAIN) begin
         thresh = '0;
      end else begin
         if (pending != 16'hFFFF) pending = pending + 16'd1;
         if (win_arrivals != 32'hFFFF_FFFF) win_arrivals = win_arrivals + 32'd1;
      end
      e.batch_count = pending;
      if (pending > thresh) begin
         if (r.send_fail) begin
            e.error_status = 1'b1;
         end else begin
            e.flush = 1'b1;
            pending = '0;
         end
      end
      win_end = win_start + 32'(WINDOW_SECONDS);
      if (!e.error_status && adapt_on && win_end < r.now_seconds) begin
         rate = win_arrivals / WINDOW_SECONDS;
         dbl  = thresh;
         dbl  = dbl * 2;
         half = thresh;
         half = half / 2;
         if (rate > dbl) begin
            thresh = (dbl > max_batch) ? max_batch : dbl[7:0];
         end else if (rate < half) begin
            thresh = (half < min_batch) ? min_batch : half[7:0];
         end
         win_arrivals = '0;
         win_start    = r.now_seconds;
      end
      e.current_threshold = thresh;
      due_responses.push_back(e);
   endfunction

   function bit check_response(rsp_payload_type got, output string msg);
      rsp_payload_type e;
      rsp_seen++;
      msg = "";
      if (due_responses.size() == 0) begin
         msg = $sformatf("response %0d arrived with none due", rsp_seen);
         return 1'b0;
      end
      e = due_responses.pop_front();
      if (got.flush !== e.flush || got.batch_count !== e.batch_count ||
          got.error_status !== e.error_status ||
          got.current_threshold !== e.current_threshold) begin
         msg = $sformatf("response %0d got/exp: flush %b/%b count %0d/%0d err %b/%b thr %0d/%0d",
                         rsp_seen, got.flush, e.flush, got.batch_count, e.batch_count,
                         got.error_status, e.error_status,
                         got.current_threshold, e.current_threshold);
         return 1'b0;
      end
      return 1'b1;
   endfunction
endclass

module testbench;

   localparam int HOLD_CYCLES = 60;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   coalescer_tracker sb = new();
   int               errors = 0;
   bit               gaps_on = 1'b1;
   bit               hold_off_req = 1'b0;
   logic [31:0]      wall_seconds = '0;

   adaptive_batch_coalescer_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic push_item(cmd_op_type op, logic [31:0] t, logic fail);
      req_payload_type r;
      int              gap;
      r.req_type    = op;
      r.now_seconds = t;
      r.send_fail   = fail;
      gap = gaps_on ? int'($urandom_range(0, 5)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(csr_reg_type r, logic [7:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= {24'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_config(r, v);
   endtask

   task automatic configure(logic [7:0] min_b, logic [7:0] max_b, logic en);
      settle();
      csr_write(REG_MIN_BATCH, min_b);
      csr_write(REG_MAX_BATCH, max_b);
      csr_write(REG_ADAPT_ENABLE, {7'd0, en});
      @(posedge clock);
   endtask

   task automatic run_traffic(int n, bit drains, bit press);
      int         per_sec;
      int         in_sec;
      bit         noisy;
      logic [31:0] t;
      cmd_op_type op;
      per_sec = $urandom_range(1, 30);
      in_sec  = 0;
      noisy   = ($urandom_range(0, 3) == 0);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (press) begin
         gaps_on      = 1'b0;
         hold_off_req = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) wall_seconds = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      for (int i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 99) < 5) begin
            wall_seconds = $urandom;
            in_sec       = 0;
         end
         t = wall_seconds;
         in_sec++;
         if (in_sec >= per_sec) begin
            in_sec       = 0;
            wall_seconds = wall_seconds + 32'd1;
         end
         op = (drains && $urandom_range(0, 99) < 6) ? OP_DRAIN : OP_ARRIVAL;
         push_item(op, t, $urandom_range(0, 99) < 10);
      end
   endtask

   task automatic run_phase(int items, bit drains, bit force_press);
      int done;
      int n;
      done = 0;
      while (done < items) begin
         n = $urandom_range(10, 40);
         run_traffic(n, drains, (force_press && done == 0) || $urandom_range(0, 5) == 0);
         done += n;
      end
   endtask

   // response side
   initial begin
      int    gap;
      string msg;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = gaps_on ? int'($urandom_range(0, 5)) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (!sb.check_response(rsp_payload, msg)) report(msg);
      end
   end

   // request side
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // time extremes and window wrap at reset settings
      push_item(OP_ARRIVAL, 32'd0, 1'b0);
      push_item(OP_ARRIVAL, 32'd0, 1'b1);
      push_item(OP_ARRIVAL, 32'hFFFF_FFFF, 1'b0);
      push_item(OP_ARRIVAL, 32'd3, 1'b0);
      push_item(OP_ARRIVAL, 32'd4, 1'b0);
      push_item(OP_ARRIVAL, 32'd5, 1'b0);
      push_item(OP_ARRIVAL, 32'h8000_0000, 1'b0);
      push_item(OP_ARRIVAL, 32'h7FFF_FFFF, 1'b1);
      push_item(OP_ARRIVAL, 32'h5555_5555, 1'b0);
      push_item(OP_ARRIVAL, 32'hAAAA_AAAA, 1'b1);

      // failed sends: the count keeps growing below the threshold, so none flushes or errors
      gaps_on = 1'b0;
      for (int i = 0; i < 24; i++) push_item(OP_ARRIVAL, 32'hAAAA_AAAA, 1'b1);
      push_item(OP_ARRIVAL, 32'hAAAA_AAB0, 1'b0);
      push_item(OP_ARRIVAL, 32'hAAAA_AAB0, 1'b0);

      wall_seconds = 32'h0000_1000;
      run_phase(90, 1'b0, 1'b1);

      configure(8'd1, 8'd255, 1'b1);
      run_phase(90, 1'b0, 1'b0);

      configure(8'd200, 8'd10, 1'b1);
      run_phase(70, 1'b0, 1'b0);

      configure(8'd3, 8'd40, 1'b0);
      run_phase(60, 1'b0, 1'b0);

      configure(8'd0, 8'd1, 1'b1);
      run_phase(70, 1'b0, 1'b0);

      // drains pin the threshold at zero
      configure(8'd255, 8'd255, 1'b1);
      gaps_on = 1'b1;
      push_item(OP_ARRIVAL, wall_seconds, 1'b0);
      push_item(OP_DRAIN, wall_seconds, 1'b1);
      push_item(OP_DRAIN, wall_seconds, 1'b0);
      push_item(OP_DRAIN, wall_seconds, 1'b0);
      push_item(OP_ARRIVAL, wall_seconds + 32'd10, 1'b0);
      push_item(OP_ARRIVAL, wall_seconds + 32'd20, 1'b1);
      run_phase(100, 1'b1, 1'b0);

      settle();
      repeat (10) @(posedge clock);
      if (errors == 0 && sb.outstanding() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ sim.f @@
sv/abc_pkg.sv
sv/abc_front.sv
sv/abc_back.sv
sv/adaptive_batch_coalescer_core.sv
tb/testbench.sv
